// ===== rtl/core/ratq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ratq_pkg;
  localparam int WAIT_DEPTH = 16;
  localparam int ACTIVE_DEPTH = 16;
  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int AAW = $clog2(ACTIVE_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int ACW = $clog2(ACTIVE_DEPTH + 1);
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_CPU = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MEM = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RATE = 2'd2;
  localparam logic [1:0] KIND_ADMIT = 2'd0;
  localparam logic [1:0] KIND_RETURN = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;
  localparam logic [9:0] BUDGET_MAX = 10'd1023;
  localparam logic [9:0] RST_TOTAL = 10'd200;
  localparam logic [15:0] RST_RATE = 16'd100;

  typedef struct packed {
    logic [31:0] owner;
    logic [19:0] size;
    logic [7:0] cpu;
    logic [7:0] mem;
  } task_t;

  typedef struct packed {
    logic        func;
    logic [31:0] requester;
    logic [19:0] task_size;
    logic [7:0]  need_cpu;
    logic [7:0]  need_memory;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] task_owner;
    logic [19:0] reported_size;
    logic [31:0] handling_time;
    logic [9:0]  cpu_left;
    logic [9:0]  memory_left;
    logic        last;
  } out_beat_t;
endpackage
`default_nettype wire

// ===== rtl/core/ratq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ratq_in_if;
  logic valid;
  logic ready;
  ratq_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ratq_out_if;
  logic valid;
  logic ready;
  ratq_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/resource_admission_task_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Task admission queue. One arrival or completion beat is taken at a time; the waiting FIFO
// and the active table are synchronous memories walked one entry at a time. An arrival and
// a completion each end with an admission pass over the waiting tasks. Each admitted task
// runs through the 52-step bit-serial divider before its result beat, and a stalled result
// output holds the walk. Each result beat is held back until the next beat or the end of
// the item shows whether it is the final one, then leaves through a one-beat output register.
// Configuration must be written only while the block is idle; the block itself does not
// enforce this rule.
module resource_admission_task_queue_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  ratq_in_if.sink   in_ch,
  ratq_out_if.source out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [ratq_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ratq_pkg::CFG_DW-1:0] cfg_data
);
  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ARR  = 12'b000000000010,
    S_CRD  = 12'b000000000100,
    S_CCHK = 12'b000000001000,
    S_SRD  = 12'b000000010000,
    S_SWR  = 12'b000000100000,
    S_PINI = 12'b000001000000,
    S_PRD  = 12'b000010000000,
    S_PCHK = 12'b000100000000,
    S_DIV  = 12'b001000000000,
    S_EMIT = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  localparam int QW = 52;
  localparam int DW = 24;

  state_t state_r;
  logic [9:0] rcpu_r, rmem_r;
  logic [15:0] rate_r;
  logic [ratq_pkg::WCW-1:0] wcnt_r, wlim_r, keep_r, widx_r;
  logic [ratq_pkg::ACW-1:0] used_r, aidx_r;
  ratq_pkg::in_beat_t ib_r;
  ratq_pkg::task_t wmem [ratq_pkg::WAIT_DEPTH];
  ratq_pkg::task_t amem [ratq_pkg::ACTIVE_DEPTH];
  ratq_pkg::task_t wrd_r, ard_r, cur_r;
  logic [QW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [5:0] dcnt_r;
  ratq_pkg::out_beat_t pend_r;
  logic pend_v_r;
  logic ov_v_r;
  ratq_pkg::out_beat_t ov_d_r;

  logic w_we, a_we;
  logic [ratq_pkg::WAW-1:0] w_wa, w_ra;
  logic [ratq_pkg::AAW-1:0] a_wa, a_ra;
  ratq_pkg::task_t w_wd, a_wd;

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    wrd_r <= wmem[w_ra];
    if (a_we) amem[a_wa] <= a_wd;
    ard_r <= amem[a_ra];
  end

  logic [9:0] csum, msum;
  logic [10:0] csum_w, msum_w;
  logic fits;
  logic [DW:0] trial;
  assign csum_w = {1'b0, rcpu_r} + {3'b0, ard_r.cpu};
  assign msum_w = {1'b0, rmem_r} + {3'b0, ard_r.mem};
  assign csum = csum_w[10] ? ratq_pkg::BUDGET_MAX : csum_w[9:0];
  assign msum = msum_w[10] ? ratq_pkg::BUDGET_MAX : msum_w[9:0];
  assign fits = ({2'b0, wrd_r.cpu} <= rcpu_r) && ({2'b0, wrd_r.mem} <= rmem_r)
                && (used_r < ratq_pkg::ACW'(ratq_pkg::ACTIVE_DEPTH));
  assign trial = {rem_r[DW-1:0], q_r[QW-1]} - {1'b0, dvs_r};

  // Output: pend_r is the beat being held; out register holds one beat.
  logic emit_en;
  ratq_pkg::out_beat_t emit_d;
  assign out_ch.valid = ov_v_r;
  assign out_ch.data = ov_d_r;
  logic out_free;
  assign out_free = !ov_v_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_v_r <= 1'b0;
    else if (emit_en) ov_v_r <= 1'b1;
    else if (out_ch.ready) ov_v_r <= 1'b0;
    if (emit_en) ov_d_r <= emit_d;
  end

  always_comb begin
    w_we = 1'b0; w_wa = widx_r[ratq_pkg::WAW-1:0]; w_wd = cur_r;
    w_ra = widx_r[ratq_pkg::WAW-1:0];
    a_we = 1'b0; a_wa = aidx_r[ratq_pkg::AAW-1:0]; a_wd = cur_r;
    a_ra = aidx_r[ratq_pkg::AAW-1:0];
    emit_en = 1'b0; emit_d = pend_r;
    unique case (state_r)
      S_ARR: begin
        w_wa = wcnt_r[ratq_pkg::WAW-1:0];
        w_wd = '{ib_r.requester, ib_r.task_size, ib_r.need_cpu, ib_r.need_memory};
        w_we = (wcnt_r < ratq_pkg::WCW'(ratq_pkg::WAIT_DEPTH));
      end
      S_SWR: begin
        a_wa = ratq_pkg::AAW'(aidx_r - 1'b1);
        a_wd = ard_r;
        a_we = 1'b1;
      end
      S_PCHK: begin
        a_wa = used_r[ratq_pkg::AAW-1:0];
        a_wd = wrd_r;
        a_we = fits;
        w_wa = keep_r[ratq_pkg::WAW-1:0];
        w_wd = wrd_r;
        w_we = !fits;
      end
      S_EMIT: begin
        emit_en = pend_v_r && out_free;
      end
      S_DONE: begin
        emit_en = pend_v_r && out_free;
        emit_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rcpu_r <= ratq_pkg::RST_TOTAL;
      rmem_r <= ratq_pkg::RST_TOTAL;
      rate_r <= ratq_pkg::RST_RATE;
      wcnt_r <= '0;
      used_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ratq_pkg::REG_CPU: rcpu_r <= cfg_data[9:0];
          ratq_pkg::REG_MEM: rmem_r <= cfg_data[9:0];
          ratq_pkg::REG_RATE: rate_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          ib_r <= in_ch.data;
          aidx_r <= '0;
          state_r <= in_ch.data.func ? S_CRD : S_ARR;
        end
        S_ARR: begin
          if (wcnt_r < ratq_pkg::WCW'(ratq_pkg::WAIT_DEPTH)) begin
            wcnt_r <= wcnt_r + 1'b1;
          end else begin
            pend_r <= '{ratq_pkg::KIND_DROP, ib_r.requester, ib_r.task_size, 32'd0,
                        rcpu_r, rmem_r, 1'b0};
            pend_v_r <= 1'b1;
          end
          state_r <= S_PINI;
        end
        S_CRD: state_r <= (aidx_r < used_r) ? S_CCHK : S_PINI;
        S_CCHK: begin
          if (ard_r.size == ib_r.task_size) begin
            rcpu_r <= csum;
            rmem_r <= msum;
            pend_r <= '{ratq_pkg::KIND_RETURN, ard_r.owner, ard_r.size, 32'd0,
                        csum, msum, 1'b0};
            aidx_r <= aidx_r + 1'b1;
            state_r <= S_SRD;
          end else begin
            aidx_r <= aidx_r + 1'b1;
            state_r <= S_CRD;
          end
        end
        S_SRD: begin
          if (aidx_r < used_r) state_r <= S_SWR;
          else begin
            used_r <= used_r - 1'b1;
            pend_v_r <= 1'b1;
            state_r <= S_PINI;
          end
        end
        S_SWR: begin
          aidx_r <= aidx_r + 1'b1;
          state_r <= S_SRD;
        end
        S_PINI: begin
          wlim_r <= wcnt_r;
          keep_r <= '0;
          widx_r <= '0;
          state_r <= S_PRD;
        end
        S_PRD: state_r <= (widx_r < wlim_r) ? S_PCHK : S_DONE;
        S_PCHK: begin
          widx_r <= widx_r + 1'b1;
          if (fits) begin
            rcpu_r <= rcpu_r - {2'b0, wrd_r.cpu};
            rmem_r <= rmem_r - {2'b0, wrd_r.mem};
            used_r <= used_r + 1'b1;
            cur_r <= wrd_r;
            q_r <= {9'b0, 27'(wrd_r.size) * 27'd100, 16'b0};
            dvs_r <= 24'(rate_r) * 24'(wrd_r.cpu);
            rem_r <= '0;
            dcnt_r <= '0;
            state_r <= S_DIV;
          end else begin
            keep_r <= keep_r + 1'b1;
            state_r <= S_PRD;
          end
        end
        S_DIV: begin
          if (!trial[DW]) begin
            rem_r <= trial[DW-1:0];
            q_r <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DW-2:0], q_r[QW-1]};
            q_r <= {q_r[QW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'(QW - 1)) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!pend_v_r || out_free) begin
            pend_r <= '{ratq_pkg::KIND_ADMIT, cur_r.owner, cur_r.size,
                        (dvs_r == '0 || q_r[QW-1:32] != '0) ? 32'hFFFFFFFF : q_r[31:0],
                        rcpu_r, rmem_r, 1'b0};
            pend_v_r <= 1'b1;
            state_r <= S_PRD;
          end
        end
        S_DONE: begin
          if (!pend_v_r || out_free) begin
            pend_v_r <= 1'b0;
            wcnt_r <= keep_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
